// ===== rtl/acip_pkg.sv =====
// Shared types, codes and constant tables of the container index parser.
// No dependencies; compiled first.
package acip_pkg;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_MAGIC = 3'd1;
   localparam logic [2:0] PH_COUNT = 3'd2;
   localparam logic [2:0] PH_LEN   = 3'd3;
   localparam logic [2:0] PH_DATA  = 3'd4;
   localparam logic [2:0] PH_TRAIL = 3'd5;

   localparam logic [2:0] KIND_ENTRY       = 3'd0;
   localparam logic [2:0] KIND_EMPTY       = 3'd1;
   localparam logic [2:0] KIND_BAD_MAGIC   = 3'd2;
   localparam logic [2:0] KIND_BAD_TRAILER = 3'd3;
   localparam logic [2:0] KIND_TOO_MANY    = 3'd4;
   localparam logic [2:0] KIND_HIT         = 3'd5;
   localparam logic [2:0] KIND_MISS        = 3'd6;

   localparam logic [3:0] MAGIC_LEN = 4'd13;
   localparam logic [3:0] TRAIL_LEN = 4'd2;
   localparam logic [3:0] WORD_LAST = 4'd3;

   typedef struct packed {
      logic        func;
      logic        start_req;
      logic [7:0]  data_byte;
      logic [31:0] query_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  entry_number;
      logic [31:0] data_offset;
      logic [31:0] data_length;
      logic        present;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        res_valid;
      rsp_type     res;
      logic        tbl_wr;
      logic [31:0] wr_off;
      logic [31:0] wr_len;
   } parse_out_type;

   function automatic logic [7:0] magic_byte(input logic [3:0] pos);
      logic [7:0] b;
      case (pos)
         4'd0:    b = 8'h01;
         4'd1:    b = 8'h63;
         4'd2:    b = 8'h61;
         4'd3:    b = 8'h72;
         4'd4:    b = 8'h72;
         4'd5:    b = 8'h61;
         4'd6:    b = 8'h79;
         4'd7:    b = 8'h01;
         4'd8:    b = 8'h66;
         4'd9:    b = 8'h69;
         4'd10:   b = 8'h6c;
         4'd11:   b = 8'h65;
         4'd12:   b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] trail_byte(input logic [3:0] pos);
      return (pos == 4'd0) ? 8'h55 : 8'hAA;
   endfunction

endpackage

// ===== rtl/acip_if.sv =====
// Valid/ready channel interfaces for request and response transfers.
// Depends on acip_pkg for the payload types.
interface acip_req_if import acip_pkg::*; ;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface acip_rsp_if import acip_pkg::*; ;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/acip_parser.sv =====
// Byte-level parse state machine: magic, count, length, data skip, trailer.
// Depends on acip_pkg; drives table writes and parse results to the top level.
module acip_parser import acip_pkg::*; #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_en,
   input  logic                  start,
   input  logic [7:0]            byte_in,
   output parse_out_type         pout,
   output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] wr_idx,
   output logic [$clog2(MAX_ENTRIES + 1)-1:0] parsed_count
);

   localparam int IDXW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNTW = $clog2(MAX_ENTRIES + 1);
   localparam logic [31:0] MAX_W = 32'(MAX_ENTRIES);

   logic [2:0]      phase_ff, phase_in;
   logic [3:0]      pos_ff, pos_in;
   logic [31:0]     off_ff, off_in;
   logic [31:0]     acc_ff, acc_in;
   logic [CNTW-1:0] total_ff, total_in;
   logic [IDXW-1:0] cur_ff, cur_in;
   logic [31:0]     skip_ff, skip_in;
   logic [CNTW-1:0] parsed_ff, parsed_in;
   logic [31:0]     cur_off_ff, cur_off_in;
   logic [31:0]     cur_len_ff, cur_len_in;

   always_comb begin
      logic [2:0]      ph;
      logic [3:0]      pos;
      logic [31:0]     off;
      logic [31:0]     acc;
      logic [31:0]     full;
      logic [CNTW-1:0] next_cnt;
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      off_in     = off_ff;
      acc_in     = acc_ff;
      total_in   = total_ff;
      cur_in     = cur_ff;
      skip_in    = skip_ff;
      parsed_in  = parsed_ff;
      cur_off_in = cur_off_ff;
      cur_len_in = cur_len_ff;
      pout       = '0;
      ph         = start ? PH_MAGIC : phase_ff;
      pos        = start ? 4'd0 : pos_ff;
      off        = start ? 32'd0 : off_ff;
      acc        = start ? 32'd0 : acc_ff;
      full       = acc | ({24'd0, byte_in} << {pos[1:0], 3'b000});
      next_cnt   = CNTW'(cur_ff) + 1'b1;
      if (byte_en) begin
         if (start) begin
            phase_in  = PH_MAGIC;
            pos_in    = 4'd0;
            off_in    = 32'd0;
            acc_in    = 32'd0;
            total_in  = '0;
            cur_in    = '0;
            skip_in   = 32'd0;
            parsed_in = '0;
         end
         if (ph != PH_IDLE) begin
            off_in = off + 32'd1;
         end
         unique case (ph)
            PH_MAGIC: begin
               if (pos >= MAGIC_LEN || byte_in != magic_byte(pos)) begin
                  phase_in       = PH_IDLE;
                  parsed_in      = '0;
                  pout.res_valid = 1'b1;
                  pout.res.kind  = KIND_BAD_MAGIC;
                  pout.res.last  = 1'b1;
               end else if (pos + 4'd1 == MAGIC_LEN) begin
                  phase_in = PH_COUNT;
                  pos_in   = 4'd0;
                  acc_in   = 32'd0;
               end else begin
                  pos_in = pos + 4'd1;
               end
            end
            PH_COUNT, PH_LEN: begin
               pos_in = pos + 4'd1;
               acc_in = full;
               if (pos == WORD_LAST) begin
                  pos_in = 4'd0;
                  acc_in = 32'd0;
                  if (ph == PH_COUNT) begin
                     if (full > MAX_W || full == 32'd0) begin
                        phase_in       = PH_IDLE;
                        parsed_in      = '0;
                        pout.res_valid = 1'b1;
                        pout.res.kind  = (full == 32'd0) ? KIND_EMPTY : KIND_TOO_MANY;
                        pout.res.last  = 1'b1;
                     end else begin
                        total_in = full[CNTW-1:0];
                        cur_in   = '0;
                        phase_in = PH_LEN;
                     end
                  end else begin
                     pout.tbl_wr = 1'b1;
                     pout.wr_off = off + 32'd1;
                     pout.wr_len = full;
                     cur_off_in  = off + 32'd1;
                     cur_len_in  = full;
                     skip_in     = full;
                     phase_in    = (full == 32'd0) ? PH_TRAIL : PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               skip_in = skip_ff - 32'd1;
               if (skip_ff == 32'd1) begin
                  phase_in = PH_TRAIL;
                  pos_in   = 4'd0;
               end
            end
            PH_TRAIL: begin
               pout.res.entry_number = 8'(cur_ff);
               pout.res.data_offset  = cur_off_ff;
               pout.res.data_length  = cur_len_ff;
               pout.res.present      = (cur_len_ff != 32'd0);
               if (pos >= TRAIL_LEN || byte_in != trail_byte(pos)) begin
                  phase_in       = PH_IDLE;
                  parsed_in      = '0;
                  pout.res_valid = 1'b1;
                  pout.res.kind  = KIND_BAD_TRAILER;
                  pout.res.last  = 1'b1;
               end else if (pos == 4'd0) begin
                  pos_in = 4'd1;
               end else begin
                  pos_in         = 4'd0;
                  parsed_in      = next_cnt;
                  pout.res_valid = 1'b1;
                  pout.res.kind  = KIND_ENTRY;
                  pout.res.last  = (next_cnt >= total_ff);
                  if (next_cnt >= total_ff) begin
                     phase_in = PH_IDLE;
                  end else begin
                     cur_in   = next_cnt[IDXW-1:0];
                     phase_in = PH_LEN;
                     acc_in   = 32'd0;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= 4'd0;
         total_ff  <= '0;
         cur_ff    <= '0;
         parsed_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         total_ff  <= total_in;
         cur_ff    <= cur_in;
         parsed_ff <= parsed_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff     <= off_in;
      acc_ff     <= acc_in;
      skip_ff    <= skip_in;
      cur_off_ff <= cur_off_in;
      cur_len_ff <= cur_len_in;
   end

   assign wr_idx       = cur_ff;
   assign parsed_count = parsed_ff;

endmodule

// ===== rtl/array_container_index_parser.sv =====
// Container index parser, top level: request/response channels, entry tables
// and response register. Depends on acip_pkg, acip_if and acip_parser.
//
// req_chan carries one item per transfer: an image byte (func 0) or a lookup
// (func 1). start_req on an image byte restarts the parse at the magic.
// rsp_chan carries zero or one result per request: parsed entries, parse
// errors and end of image, and lookup hit or miss.
// An image byte is taken every cycle req_chan.ready is high; its result,
// if any, is in the response register in the cycle after the transfer. A
// lookup reads the offset and length tables, synchronous memories, into read
// registers and then the response register; req_chan.ready is low between.
// While a response waits, a new request is taken only if the receiver takes
// the waiting one in the same cycle; otherwise req_chan.ready stays low.
// Synchronous reset returns the parser to idle with no parsed entries; the
// tables keep their contents and need no clearing, since only entries of the
// current parse can hit.
module array_container_index_parser import acip_pkg::*; #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic       clock,
   input  logic       reset,
   acip_req_if.sink   req_chan,
   acip_rsp_if.source rsp_chan
);

   localparam int IDXW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNTW = $clog2(MAX_ENTRIES + 1);

   logic            req_xfer;
   logic            byte_en;
   logic            look_en;
   logic            look_hit;
   parse_out_type   pout;
   logic [IDXW-1:0] wr_idx;
   logic [CNTW-1:0] parsed_count;

   logic [31:0] off_mem [MAX_ENTRIES];
   logic [31:0] len_mem [MAX_ENTRIES];
   logic [31:0] rd_off_ff;
   logic [31:0] rd_len_ff;

   logic        look_pend_ff, look_pend_in;
   logic        look_hit_ff;
   logic [7:0]  look_num_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   assign req_chan.ready = !look_pend_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign byte_en        = req_xfer && !req_chan.data.func;
   assign look_en        = req_xfer && req_chan.data.func;
   assign look_hit       = req_chan.data.query_index < 32'(parsed_count);

   acip_parser #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_en     (byte_en),
      .start       (req_chan.data.start_req),
      .byte_in     (req_chan.data.data_byte),
      .pout        (pout),
      .wr_idx      (wr_idx),
      .parsed_count(parsed_count)
   );

   always_ff @(posedge clock) begin
      if (pout.tbl_wr) begin
         off_mem[wr_idx] <= pout.wr_off;
         len_mem[wr_idx] <= pout.wr_len;
      end
      if (look_en) begin
         rd_off_ff <= off_mem[req_chan.data.query_index[IDXW-1:0]];
         rd_len_ff <= len_mem[req_chan.data.query_index[IDXW-1:0]];
      end
   end

   always_comb begin
      look_pend_in = look_en;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      if (look_pend_ff) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in               = '0;
         rsp_data_in.entry_number  = look_num_ff;
         if (look_hit_ff) begin
            rsp_data_in.kind        = KIND_HIT;
            rsp_data_in.data_offset = rd_off_ff;
            rsp_data_in.data_length = rd_len_ff;
            rsp_data_in.present     = (rd_len_ff != 32'd0);
         end else begin
            rsp_data_in.kind        = KIND_MISS;
         end
      end else if (pout.res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pout.res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         look_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         look_pend_ff <= look_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (look_en) begin
         look_hit_ff <= look_hit;
         look_num_ff <= req_chan.data.query_index[7:0];
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // response register is empty when the table read lands
   a_look_slot_free: assert property (@(posedge clock) disable iff (reset)
      look_pend_ff |-> !rsp_valid_ff)
      else $error("lookup data arrived with response register occupied");

   a_look_loads: assert property (@(posedge clock) disable iff (reset)
      look_pend_ff |=> rsp_valid_ff)
      else $error("lookup produced no response");

   // an entry being written is never one that a lookup can hit
   a_wr_above_parsed: assert property (@(posedge clock) disable iff (reset)
      pout.tbl_wr |-> (CNTW'(wr_idx) >= parsed_count))
      else $error("table write to an entry already reported");

   a_parsed_bound: assert property (@(posedge clock) disable iff (reset)
      32'(parsed_count) <= 32'(MAX_ENTRIES))
      else $error("parsed count above table depth");

endmodule

// ===== tb/array_container_index_parser_tb.sv =====
// Self-checking testbench for array_container_index_parser: streams container images and
// lookups with random gaps and stalls, and checks every result against a behavioral shadow.
// Depends on acip_pkg, acip_if and the parser RTL.
module array_container_index_parser_tb import acip_pkg::*; ;

   localparam int MAX_ENTRIES = 256;
   localparam int RANDOM_ITEMS = 250;
   localparam int LIMIT_CYCLES = 400000;
   localparam logic [103:0] IMAGE_MAGIC = 104'h01_63_61_72_72_61_79_01_66_69_6c_65_01;
   localparam logic [7:0] TRAIL_FIRST = 8'h55;
   localparam logic [7:0] TRAIL_SECOND = 8'hAA;

   logic clock;
   logic reset;

   acip_req_if req_chan ();
   acip_rsp_if rsp_chan ();

   array_container_index_parser #(.MAX_ENTRIES(MAX_ENTRIES)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow parser state
   logic [2:0]  parse_phase = PH_IDLE;
   int          field_pos = 0;
   logic [31:0] image_pos = '0;
   logic [31:0] field_word = '0;
   logic [31:0] entry_count = '0;
   logic [8:0]  entry_idx = '0;
   logic [31:0] data_left = '0;
   logic [8:0]  entries_done = '0;
   logic [31:0] entry_offsets [MAX_ENTRIES];
   logic [31:0] entry_lengths [MAX_ENTRIES];

   req_type outgoing_items [$];
   rsp_type awaited_results [$];
   bit      req_offering = 1'b0;
   bit      no_gaps = 1'b0;
   int      rsp_hold_left = 0;
   int      issued_items = 0;
   int      noise_items = 0;
   int      accepted_items = 0;
   int      checked_results = 0;
   int      mismatches = 0;
   int      kind_seen [8] = '{default: 0};

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] magic_at(input int pos);
      return IMAGE_MAGIC[8 * (12 - pos) +: 8];
   endfunction

   function automatic int unsigned draw_wait();
      return no_gaps ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic rsp_type make_result(input logic [2:0] kind, input logic [7:0] num,
                                           input logic [31:0] off, input logic [31:0] len,
                                           input logic last);
      rsp_type r;
      r.kind = kind;
      r.entry_number = num;
      r.data_offset = off;
      r.data_length = len;
      r.present = (len != 0);
      r.last = last;
      return r;
   endfunction

   task automatic abort_parse(input logic [2:0] kind, input logic [7:0] num,
                              input logic [31:0] off, input logic [31:0] len);
      parse_phase = PH_IDLE;
      entries_done = '0;
      awaited_results.push_back(make_result(kind, num, off, len, 1'b1));
   endtask

   // Shadow of the parser: updates state for one transfer and queues its result.
   task automatic advance_parser(input req_type it);
      logic [31:0] q;
      logic [7:0]  b;
      logic [31:0] off;
      logic [31:0] len;
      logic        done;
      q = it.query_index;
      b = it.data_byte;
      if (it.func) begin
         if (q < {23'd0, entries_done})
            awaited_results.push_back(make_result(KIND_HIT, q[7:0], entry_offsets[q[7:0]],
                                                  entry_lengths[q[7:0]], 1'b0));
         else
            awaited_results.push_back(make_result(KIND_MISS, q[7:0], '0, '0, 1'b0));
         return;
      end
      if (it.start_req) begin
         parse_phase = PH_MAGIC;
         field_pos = 0;
         image_pos = '0;
         field_word = '0;
         entry_count = '0;
         entry_idx = '0;
         data_left = '0;
         entries_done = '0;
      end
      if (parse_phase == PH_IDLE)
         return;
      image_pos = image_pos + 32'd1;
      case (parse_phase)
         PH_MAGIC: begin
            if (b != magic_at(field_pos)) begin
               abort_parse(KIND_BAD_MAGIC, '0, '0, '0);
            end else begin
               field_pos++;
               if (field_pos == MAGIC_LEN) begin
                  parse_phase = PH_COUNT;
                  field_pos = 0;
                  field_word = '0;
               end
            end
         end
         PH_COUNT, PH_LEN: begin
            field_word = field_word | ({24'd0, b} << (8 * field_pos));
            field_pos++;
            if (field_pos > WORD_LAST) begin
               field_pos = 0;
               if (parse_phase == PH_COUNT) begin
                  if (field_word > MAX_ENTRIES) begin
                     abort_parse(KIND_TOO_MANY, '0, '0, '0);
                  end else if (field_word == 0) begin
                     abort_parse(KIND_EMPTY, '0, '0, '0);
                  end else begin
                     entry_count = field_word;
                     entry_idx = '0;
                     parse_phase = PH_LEN;
                  end
               end else begin
                  entry_offsets[entry_idx[7:0]] = image_pos;
                  entry_lengths[entry_idx[7:0]] = field_word;
                  data_left = field_word;
                  parse_phase = (field_word == 0) ? PH_TRAIL : PH_DATA;
               end
               field_word = '0;
            end
         end
         PH_DATA: begin
            data_left = data_left - 32'd1;
            if (data_left == 0) begin
               parse_phase = PH_TRAIL;
               field_pos = 0;
            end
         end
         PH_TRAIL: begin
            off = entry_offsets[entry_idx[7:0]];
            len = entry_lengths[entry_idx[7:0]];
            if (b != ((field_pos == 0) ? TRAIL_FIRST : TRAIL_SECOND)) begin
               abort_parse(KIND_BAD_TRAILER, entry_idx[7:0], off, len);
            end else begin
               field_pos++;
               if (field_pos == TRAIL_LEN) begin
                  field_pos = 0;
                  entries_done = entry_idx + 9'd1;
                  done = ({23'd0, entry_idx} + 32'd1 >= entry_count);
                  awaited_results.push_back(make_result(KIND_ENTRY, entry_idx[7:0], off, len,
                                                        done));
                  if (done) begin
                     parse_phase = PH_IDLE;
                  end else begin
                     entry_idx = entry_idx + 9'd1;
                     parse_phase = PH_LEN;
                     field_word = '0;
                  end
               end
            end
         end
         default: parse_phase = PH_IDLE;
      endcase
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      checked_results++;
      if (awaited_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: kind %0d entry %0d offset %h length %h",
                     got.kind, got.entry_number, got.data_offset, got.data_length);
         return;
      end
      want = awaited_results.pop_front();
      kind_seen[want.kind]++;
      if (got.kind !== want.kind || got.entry_number !== want.entry_number ||
          got.data_offset !== want.data_offset || got.data_length !== want.data_length ||
          got.present !== want.present || got.last !== want.last) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch at result %0d (exp/got): kind %0d/%0d entry %0d/%0d",
                     checked_results, want.kind, got.kind, want.entry_number,
                     got.entry_number);
            $display("   offset %h/%h length %h/%h present %b/%b last %b/%b",
                     want.data_offset, got.data_offset, want.data_length,
                     got.data_length, want.present, got.present, want.last, got.last);
         end
      end
   endtask

   // request side: one transfer per offered item, random gap after each transfer
   initial begin : req_driver
      req_type     cur_item;
      int unsigned gap_left;
      req_chan.valid <= 1'b0;
      req_chan.data <= '0;
      gap_left = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (req_offering && req_chan.ready) begin
            advance_parser(cur_item);
            accepted_items++;
            req_offering = 1'b0;
            gap_left = draw_wait();
         end
         if (!req_offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (outgoing_items.size() > 0) begin
               cur_item = outgoing_items.pop_front();
               req_chan.data <= cur_item;
               req_offering = 1'b1;
            end
         end
         req_chan.valid <= req_offering;
         @(posedge clock);
      end
   end

   // response side: random stall after each transfer, long hold on request
   initial begin : rsp_monitor
      int unsigned stall_left;
      rsp_chan.ready <= 1'b0;
      stall_left = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            check_result(rsp_chan.data);
            stall_left = draw_wait();
         end else if (rsp_hold_left > 0) begin
            rsp_hold_left--;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_chan.ready <= (rsp_hold_left == 0 && stall_left == 0);
         @(posedge clock);
      end
   end

   task automatic send_item(input logic func, input logic start, input logic [7:0] b,
                            input logic [31:0] q);
      req_type it;
      it.func = func;
      it.start_req = start;
      it.data_byte = b;
      it.query_index = q;
      outgoing_items.push_back(it);
      issued_items++;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic start);
      send_item(1'b0, start, b, $urandom);
   endtask

   task automatic send_lookup(input logic [31:0] q);
      send_item(1'b1, 1'($urandom_range(0, 1)), 8'($urandom), q);
   endtask

   task automatic send_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++)
         send_byte(w[8 * i +: 8], 1'b0);
   endtask

   task automatic send_magic();
      for (int i = 0; i < MAGIC_LEN; i++)
         send_byte(magic_at(i), i == 0);
   endtask

   function automatic logic [31:0] pick_query(input int limit);
      case ($urandom_range(0, 9))
         7:       return $urandom;
         8:       return 32'hFFFF_FFFF;
         9:       return $urandom_range(MAX_ENTRIES - 6, MAX_ENTRIES + 6);
         default: return $urandom_range(0, limit);
      endcase
   endfunction

   task automatic wait_idle();
      int spins;
      spins = 0;
      do begin
         @(posedge clock);
         spins++;
      end while ((req_offering || outgoing_items.size() != 0 || awaited_results.size() != 0)
                 && spins < 20000);
   endtask

   // idle bytes, lookups with nothing parsed, start on a lookup, bad magic at both ends
   task automatic test_directed_corners();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_lookup(32'd0);
      send_lookup(32'hFFFF_FFFF);
      send_item(1'b1, 1'b1, 8'h01, 32'd1);
      send_byte(8'h02, 1'b1);
      for (int i = 0; i < MAGIC_LEN - 1; i++)
         send_byte(magic_at(i), i == 0);
      send_byte(8'h00, 1'b0);
      wait_idle();
   endtask

   // image with the largest entry count, mostly null entries, then edge lookups
   task automatic test_full_table();
      logic [31:0] len;
      send_magic();
      send_word(MAX_ENTRIES);
      for (int e = 0; e < MAX_ENTRIES; e++) begin
         len = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(1, 2)) : 32'd0;
         send_word(len);
         repeat (len) send_byte(8'($urandom), 1'b0);
         send_byte(TRAIL_FIRST, 1'b0);
         send_byte(TRAIL_SECOND, 1'b0);
         if ($urandom_range(0, 15) == 0)
            send_lookup(pick_query(e + 1));
      end
      send_lookup(32'd0);
      send_lookup(MAX_ENTRIES - 1);
      send_lookup(MAX_ENTRIES);
      send_lookup(32'hFFFF_FFFF);
      wait_idle();
   endtask

   // receiver holds off while lookups and a short image keep coming
   task automatic test_result_backpressure();
      no_gaps = 1'b1;
      rsp_hold_left = 200;
      repeat (40) send_lookup($urandom_range(0, MAX_ENTRIES + 8));
      send_magic();
      send_word(32'd1);
      send_word(32'd2);
      send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b0);
      send_byte(TRAIL_FIRST, 1'b0);
      send_byte(TRAIL_SECOND, 1'b0);
      send_lookup(32'd0);
      send_lookup(32'd1);
      wait_idle();
      no_gaps = 1'b0;
   endtask

   task automatic send_random_image();
      int          pick;
      int          n_entries;
      int          bad_entry;
      int          cut_entry;
      int          pos;
      logic [31:0] word;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         pos = $urandom_range(0, MAGIC_LEN - 1);
         for (int i = 0; i < pos; i++)
            send_byte(magic_at(i), i == 0);
         send_byte(magic_at(pos) ^ 8'($urandom_range(1, 255)), pos == 0);
         return;
      end
      send_magic();
      if (pick < 16) begin
         case ($urandom_range(0, 3))
            0: word = '0;
            1: word = MAX_ENTRIES + 1;
            2: word = 32'hFFFF_FFFF;
            default: begin
               word = $urandom;
               if (word <= MAX_ENTRIES)
                  word = word + MAX_ENTRIES + 1;
            end
         endcase
         send_word(word);
         return;
      end
      n_entries = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
      bad_entry = (pick < 28) ? $urandom_range(0, n_entries - 1) : -1;
      cut_entry = (pick >= 90) ? $urandom_range(0, n_entries - 1) : -1;
      send_word(n_entries);
      for (int e = 0; e < n_entries; e++) begin
         if (e == cut_entry) begin
            // parse left open; the next image restarts it
            send_word($urandom);
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom), 1'b0);
            return;
         end
         word = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
         send_word(word);
         repeat (word) send_byte(8'($urandom), 1'b0);
         if (e == bad_entry) begin
            if ($urandom_range(0, 1)) begin
               send_byte(TRAIL_FIRST, 1'b0);
               send_byte(TRAIL_SECOND ^ 8'($urandom_range(1, 255)), 1'b0);
            end else begin
               send_byte(TRAIL_FIRST ^ 8'($urandom_range(1, 255)), 1'b0);
            end
            return;
         end
         send_byte(TRAIL_FIRST, 1'b0);
         send_byte(TRAIL_SECOND, 1'b0);
         if ($urandom_range(0, 3) == 0)
            send_lookup(pick_query(e + 1));
      end
   endtask

   task automatic test_random_images();
      int first;
      first = issued_items - noise_items;
      while (issued_items - noise_items - first < RANDOM_ITEMS) begin
         no_gaps = ($urandom_range(0, 4) == 0);
         send_random_image();
         repeat ($urandom_range(0, 3)) send_lookup(pick_query($urandom_range(0, 20)));
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 2)) begin
               send_byte(8'($urandom), 1'b0);
               noise_items++;
            end
         end
         wait_idle();
      end
      no_gaps = 1'b0;
   endtask

   initial begin : test_sequence
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_full_table();
      test_result_backpressure();
      test_random_images();
      wait_idle();
      repeat (8) @(posedge clock);
      $display("Run covered %0d transfers in and %0d results checked.",
               accepted_items, checked_results);
      $display("Kinds seen: entry %0d, empty %0d, bad magic %0d, bad trailer %0d, %s%0d, %s%0d, %s%0d",
               kind_seen[KIND_ENTRY], kind_seen[KIND_EMPTY], kind_seen[KIND_BAD_MAGIC],
               kind_seen[KIND_BAD_TRAILER], "too many ", kind_seen[KIND_TOO_MANY],
               "hit ", kind_seen[KIND_HIT], "miss ", kind_seen[KIND_MISS]);
      if (awaited_results.size() != 0)
         $display("%0d expected results never arrived", awaited_results.size());
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("** array_container_index_parser: PASSED **");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("** array_container_index_parser: FAILED **");
      end
      $finish;
   end

   initial begin : run_limit
      #(LIMIT_CYCLES * 12);
      $display("timeout after %0d cycles", LIMIT_CYCLES);
      $display("** array_container_index_parser: FAILED **");
      $finish;
   end

endmodule
